// ===== rtl/sfr_pkg.sv =====
// package: shared types and constants of the serial command frame receiver
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

  localparam int unsigned MaxActuatorsDefault = 8;
  localparam logic [7:0]  SlaveAddrReset      = 8'd1;
  localparam logic [7:0]  HeaderByte          = 8'hFF;
  localparam logic [7:0]  TerminatorByte      = 8'h00;
  localparam logic [1:0]  HdrInPayload        = 2'd3;
  localparam logic [1:0]  HdrTwoSeen          = 2'd2;

  // payload positions before the actuator bytes
  localparam logic [1:0]  PosMode             = 2'd0;
  localparam logic [1:0]  PosCount            = 2'd1;
  localparam logic [1:0]  PosSensor           = 2'd2;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_READ,
    ST_SEND
  } state_e;

  typedef struct packed {
    logic rx_en;     // input transaction taken this cycle
    logic rd_issue;  // read actuator bytes at current index
    logic advance;   // move to next actuator
  } cmd_t;

  typedef struct packed {
    logic frame_end; // current byte is a zero terminator of a good frame
    logic empty;     // frame holds no actuators
    logic last;      // current result is the last of the frame
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/serial_command_frame_receiver_top.sv =====
// top level of the serial command frame receiver
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid_i/tready_o       tdata[7:0] rx_byte
//   m_axis    out  m_axis_tvalid_o/tready_i       tdata, tuser value_present, tlast
//   cfg       in   cfg_valid_i/cfg_ready_o        cfg_data_i slave_address
//
// one received byte is taken per cycle while a frame is being collected
// each actuator result takes a store read, then a send that waits out any
// output stall; the single result of an empty frame takes only the send
// no byte is taken until the last result has gone
// reset clears the header hunt and sets the slave address to 1
// the configuration channel is always ready
`timescale 1ns / 1ps
`default_nettype none

module serial_command_frame_receiver_top
  import sfr_pkg::*;
#(
  parameter int unsigned MAX_ACTUATORS = MaxActuatorsDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  // [7:0] frame_mode, [15:8] sensor_count, [18:16] actuator_index,
  // [34:19] actuator_value, [39:35] zero
  output logic [39:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o,   // [0] value_present
  output logic        m_axis_tlast_o,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [7:0]  cfg_data_i
);

  cmd_t        cmd;
  status_t     status;
  logic [7:0]  frame_mode;
  logic [7:0]  sensor_count;
  logic [2:0]  actuator_index;
  logic [15:0] actuator_value;

  assign cfg_ready_o = 1'b1;

  sfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sfr_datapath #(
    .MAX_ACTUATORS (MAX_ACTUATORS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_byte_i        (s_axis_tdata_i),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .frame_mode_o     (frame_mode),
    .sensor_count_o   (sensor_count),
    .actuator_index_o (actuator_index),
    .actuator_value_o (actuator_value),
    .value_present_o  (m_axis_tuser_o),
    .last_of_frame_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {5'd0, actuator_value, actuator_index, sensor_count, frame_mode};

endmodule

`default_nettype wire

// ===== rtl/sfr_ctrl.sv =====
// controller: receive, read and send sequencing
`timescale 1ns / 1ps
`default_nettype none

module sfr_ctrl
  import sfr_pkg::*;
(
  input  wire     clk_i,
  input  wire     rst_ni,
  input  wire     in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  wire     out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RECV;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_RECV: begin
        in_ready_o   = 1'b1;
        cmd_o.rx_en  = in_valid_i;
        if (in_valid_i && status_i.frame_end) begin
          state_d = status_i.empty ? ST_SEND : ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_SEND;
      end
      ST_SEND: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.last) begin
            state_d = ST_RECV;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_RECV;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/sfr_datapath.sv =====
// datapath: header hunt, payload capture, actuator store and value decode
`timescale 1ns / 1ps
`default_nettype none

module sfr_datapath
  import sfr_pkg::*;
#(
  parameter int unsigned MAX_ACTUATORS = MaxActuatorsDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire  [7:0]  rx_byte_i,
  input  wire         cfg_we_i,
  input  wire  [7:0]  cfg_data_i,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  output logic [7:0]  frame_mode_o,
  output logic [7:0]  sensor_count_o,
  output logic [2:0]  actuator_index_o,
  output logic [15:0] actuator_value_o,
  output logic        value_present_o,
  output logic        last_of_frame_o
);

  localparam int unsigned Depth = 2 * MAX_ACTUATORS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned PW    = $clog2(Depth + 4);
  localparam int unsigned KW    = (MAX_ACTUATORS > 1) ? $clog2(MAX_ACTUATORS) : 1;

  logic [7:0]    slave_addr_q;
  logic [1:0]    hdr_q, hdr_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [7:0]    mode_q, mode_d;
  logic [7:0]    count_q, count_d;
  logic [7:0]    sensor_q, sensor_d;
  logic [KW-1:0] k_q;
  logic          present_q;
  logic [7:0]    lo_q, hi_q;
  logic [7:0]    mem [Depth];

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [9:0]    data_end;
  logic          frame_end;
  logic [14:0]   mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= SlaveAddrReset;
    end else if (cfg_we_i) begin
      slave_addr_q <= cfg_data_i;
    end
  end

  // first position past the actuator bytes holds the terminator
  assign data_end = {1'b0, count_q, 1'b0} + 10'd3;

  always_comb begin
    hdr_d     = hdr_q;
    pos_d     = pos_q;
    mode_d    = mode_q;
    count_d   = count_q;
    sensor_d  = sensor_q;
    wr_en     = 1'b0;
    wr_addr   = AW'(pos_q - PW'(3));
    frame_end = 1'b0;
    if (hdr_q != HdrInPayload) begin
      pos_d = '0;
      if (rx_byte_i == HeaderByte) begin
        hdr_d = hdr_q + 2'd1;
      end else if (hdr_q == HdrTwoSeen && rx_byte_i == slave_addr_q) begin
        hdr_d = HdrInPayload;
      end else begin
        hdr_d = '0;
      end
    end else if (pos_q == PW'(PosMode)) begin
      mode_d = rx_byte_i;
      pos_d  = PW'(PosCount);
    end else if (pos_q == PW'(PosCount)) begin
      count_d = rx_byte_i;
      if (rx_byte_i > 8'(MAX_ACTUATORS)) begin
        hdr_d = '0;
        pos_d = '0;
      end else begin
        pos_d = PW'(PosSensor);
      end
    end else if (pos_q == PW'(PosSensor)) begin
      sensor_d = rx_byte_i;
      pos_d    = PW'(3);
    end else if (10'(pos_q) < data_end) begin
      wr_en = 1'b1;
      pos_d = pos_q + PW'(1);
    end else begin
      hdr_d     = '0;
      pos_d     = '0;
      frame_end = (rx_byte_i == TerminatorByte);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q     <= '0;
      pos_q     <= '0;
      mode_q    <= '0;
      count_q   <= '0;
      sensor_q  <= '0;
      k_q       <= '0;
      present_q <= 1'b0;
    end else begin
      if (cmd_i.rx_en) begin
        hdr_q    <= hdr_d;
        pos_q    <= pos_d;
        mode_q   <= mode_d;
        count_q  <= count_d;
        sensor_q <= sensor_d;
        if (frame_end) begin
          k_q       <= '0;
          present_q <= (count_q != 8'd0);
        end
      end
      if (cmd_i.advance) begin
        k_q <= k_q + KW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rx_en && wr_en) begin
      mem[wr_addr] <= rx_byte_i;
    end
    if (cmd_i.rd_issue) begin
      lo_q <= mem[AW'({k_q, 1'b0})];
      hi_q <= mem[AW'({k_q, 1'b1})];
    end
  end

  assign status_o.frame_end = frame_end;
  assign status_o.empty     = (count_q == 8'd0);
  assign status_o.last      = !present_q || (8'(k_q) + 8'd1 == count_q);

  // sign-magnitude to two's complement, negative zero folds to zero
  assign mag = {hi_q[6:0], lo_q};

  always_comb begin
    frame_mode_o     = mode_q;
    sensor_count_o   = sensor_q;
    value_present_o  = present_q;
    last_of_frame_o  = status_o.last;
    actuator_index_o = '0;
    actuator_value_o = '0;
    if (present_q) begin
      actuator_index_o = 3'(k_q);
      actuator_value_o = hi_q[7] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
    end
  end

endmodule

`default_nettype wire
